// ===== hw/rtl/tms_pkg.sv =====
// tms_pkg: shared constants, codes and types of the Turing machine stepper.
// No dependencies; used by every file under hw/rtl.
package tms_pkg;

  localparam int TAPE_CELLS  = 512;
  localparam int MAX_STATES  = 8;
  localparam int MAX_SYMBOLS = 4;

  localparam int HEAD_W     = $clog2(TAPE_CELLS);
  localparam int STATE_W    = $clog2(MAX_STATES);
  localparam int SYM_W      = $clog2(MAX_SYMBOLS);
  localparam int IDX_W      = STATE_W + SYM_W;
  localparam int TABLE_SIZE = MAX_STATES * MAX_SYMBOLS;

  // configuration port
  localparam int SCNT_W     = 4;
  localparam int YCNT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // tape read tree: eight lanes per level, three levels
  localparam int TREE_W = 3;
  localparam int LANES  = 1 << TREE_W;
  localparam int GRP1   = TAPE_CELLS / LANES;
  localparam int GRP2   = GRP1 / LANES;
  localparam int SEL1_W = HEAD_W - TREE_W;
  localparam int SEL2_W = HEAD_W - 2 * TREE_W;

  // stream widths
  localparam int OP_W       = 2;
  localparam int S_FIELD_W  = STATE_W + SYM_W + SYM_W + 1 + STATE_W + 1 + HEAD_W;
  localparam int S_DATA_W   = ((S_FIELD_W + 7) / 8) * 8;
  localparam int M_FIELD_W  = STATE_W + HEAD_W + SYM_W + 1 + 1 + 1 + SYM_W + 1;
  localparam int M_DATA_W   = ((M_FIELD_W + 7) / 8) * 8;

  localparam logic [HEAD_W-1:0] HEAD_RESET = HEAD_W'(TAPE_CELLS / 2);
  localparam logic [HEAD_W-1:0] HEAD_LAST  = HEAD_W'(TAPE_CELLS - 1);
  localparam logic [SCNT_W-1:0] SCNT_MAX   = SCNT_W'(MAX_STATES);
  localparam logic [YCNT_W-1:0] YCNT_MAX   = YCNT_W'(MAX_SYMBOLS);
  localparam logic [SCNT_W-1:0] SCNT_RESET = SCNT_W'(2);
  localparam logic [YCNT_W-1:0] YCNT_RESET = YCNT_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATE_COUNT  = 1'b0,
    REG_SYMBOL_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SYM_W-1:0]   write_sym;
    logic               right;
    logic [STATE_W-1:0] next;
    logic               halts;
  } rule_t;

  localparam rule_t RULE_RESET = '{write_sym: '0, right: 1'b0, next: '0, halts: 1'b1};

  // per-cycle command to the tape ring
  typedef struct packed {
    logic             clr;
    logic             shift;
    logic             right;
    logic             we;
    logic [SYM_W-1:0] wd;
  } tape_ctl_t;

  // result fields carried down the pipeline (cell symbol joins at the end)
  typedef struct packed {
    logic [STATE_W-1:0] state;
    logic [HEAD_W-1:0]  head;
    logic [SYM_W-1:0]   sym_written;
    logic               moved_right;
    logic               halted;
    logic               off_tape;
    logic               load_error;
    logic               rd;
  } res_t;

endpackage

// ===== hw/rtl/tms_tape_cell.sv =====
// tms_tape_cell: one tape cell of the rotating tape ring.
// Depends on tms_pkg.
module tms_tape_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  tms_pkg::tape_ctl_t       ctl,
  input  logic [tms_pkg::SYM_W-1:0] lo,   // neighbour below, after its write
  input  logic [tms_pkg::SYM_W-1:0] hi,   // neighbour above, after its write
  output logic [tms_pkg::SYM_W-1:0] q,
  output logic [tms_pkg::SYM_W-1:0] qw    // value after this cycle's write
);

  assign qw = ctl.we ? ctl.wd : q;

  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= ctl.right ? hi : lo;
    end else if (ctl.we) begin
      q <= ctl.wd;
    end
  end

endmodule

// ===== hw/rtl/tms_tape.sv =====
// tms_tape: ring of tape cells rotated so the head always sits in cell 0,
// plus a three-level registered read tree. Depends on tms_pkg, tms_tape_cell.
module tms_tape (
  input  logic                        clk,
  input  logic                        rst,
  input  tms_pkg::tape_ctl_t          ctl,
  output logic [tms_pkg::SYM_W-1:0]   head_sym,
  input  logic                        rd_ld,    // capture level 1 for a read
  input  logic [tms_pkg::HEAD_W-1:0]  rd_addr,  // ring position to read
  input  logic                        rd_adv,   // level 1 moves to level 2
  output logic [tms_pkg::SYM_W-1:0]   cell_sym
);

  localparam int N = tms_pkg::TAPE_CELLS;

  tms_pkg::tape_ctl_t ctl_rest;
  logic [tms_pkg::SYM_W-1:0] q  [N];
  logic [tms_pkg::SYM_W-1:0] qw [N];

  // only the cell under the head is ever written
  always_comb begin
    ctl_rest    = ctl;
    ctl_rest.we = 1'b0;
  end

  for (genvar p = 0; p < N; p++) begin : g_cell
    if (p == 0) begin : g_head
      tms_tape_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .lo(qw[N-1]), .hi(qw[1]), .q(q[p]), .qw(qw[p])
      );
    end else begin : g_body
      tms_tape_cell u_cell (
        .clk(clk), .rst(rst), .ctl(ctl_rest),
        .lo(qw[p-1]), .hi(qw[(p+1)%N]), .q(q[p]), .qw(qw[p])
      );
    end
  end

  assign head_sym = q[0];

  // read tree
  logic [tms_pkg::SYM_W-1:0]  lvl1 [tms_pkg::GRP1];
  logic [tms_pkg::SYM_W-1:0]  lvl2 [tms_pkg::GRP2];
  logic [tms_pkg::SEL1_W-1:0] sel1;
  logic [tms_pkg::SEL2_W-1:0] sel2;

  for (genvar g = 0; g < tms_pkg::GRP1; g++) begin : g_lvl1
    logic [tms_pkg::SYM_W-1:0] lane [tms_pkg::LANES];
    for (genvar l = 0; l < tms_pkg::LANES; l++) begin : g_lane
      assign lane[l] = q[g*tms_pkg::LANES + l];
    end
    always_ff @(posedge clk) begin
      if (rd_ld) begin
        lvl1[g] <= lane[rd_addr[tms_pkg::TREE_W-1:0]];
      end
    end
  end

  for (genvar j = 0; j < tms_pkg::GRP2; j++) begin : g_lvl2
    logic [tms_pkg::SYM_W-1:0] lane [tms_pkg::LANES];
    for (genvar l = 0; l < tms_pkg::LANES; l++) begin : g_lane
      assign lane[l] = lvl1[j*tms_pkg::LANES + l];
    end
    always_ff @(posedge clk) begin
      if (rd_adv) begin
        lvl2[j] <= lane[sel1[tms_pkg::TREE_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_ld) begin
      sel1 <= rd_addr[tms_pkg::HEAD_W-1:tms_pkg::TREE_W];
    end
    if (rd_adv) begin
      sel2 <= sel1[tms_pkg::SEL1_W-1:tms_pkg::TREE_W];
    end
  end

  assign cell_sym = lvl2[sel2];

endmodule

// ===== hw/rtl/tms_rule_table.sv =====
// tms_rule_table: transition table, one rule per (state, read symbol).
// Depends on tms_pkg.
module tms_rule_table (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [tms_pkg::IDX_W-1:0]  waddr,
  input  tms_pkg::rule_t             wdata,
  input  logic [tms_pkg::IDX_W-1:0]  raddr,
  output tms_pkg::rule_t             rdata
);

  tms_pkg::rule_t rules [tms_pkg::TABLE_SIZE];

  // reset: every rule writes zero and halts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tms_pkg::TABLE_SIZE; i++) begin
        rules[i] <= tms_pkg::RULE_RESET;
      end
    end else if (we) begin
      rules[waddr] <= wdata;
    end
  end

  assign rdata = rules[raddr];

endmodule

// ===== hw/rtl/turing_machine_stepper.sv =====
// turing_machine_stepper: top level of the Turing machine engine.
// Three register stages (r1, r2, r3); the stage count is set by the tape read tree.
// Throughput: one item per cycle unless m_axis_tready holds the output back.
// Reset (rst, synchronous): tape all zero, head at cell 256, state 0, flags clear,
// every rule writes zero and halts, both counts 2. Depends on tms_pkg,
// tms_tape_cell, tms_tape, tms_rule_table.
module turing_machine_stepper (
  input  logic                             clk,
  input  logic                             rst,
  // in: entry_state, entry_symbol, entry_write, entry_right, entry_next,
  //     entry_halts, cell_index (lowest bits first), zero fill
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [tms_pkg::S_DATA_W-1:0]     s_axis_tdata,
  input  logic [tms_pkg::OP_W-1:0]         s_axis_tuser,   // op
  // out: machine_state, head_pos, symbol_written, moved_right, halted,
  //      off_tape, cell_symbol, load_error (lowest bits first), zero fill
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [tms_pkg::M_DATA_W-1:0]     m_axis_tdata,
  // configuration: 0 state_count, 1 symbol_count
  input  logic                             cfg_we,
  input  logic [tms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [tms_pkg::SCNT_W-1:0] state_count;
  logic [tms_pkg::YCNT_W-1:0] symbol_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count  <= tms_pkg::SCNT_RESET;
      symbol_count <= tms_pkg::YCNT_RESET;
    end else if (cfg_we) begin
      case (tms_pkg::reg_idx_t'(cfg_index))
        tms_pkg::REG_STATE_COUNT:  state_count  <= cfg_data;
        tms_pkg::REG_SYMBOL_COUNT: symbol_count <= cfg_data[tms_pkg::YCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input item fields
  // ---------------------------------------------------------------------------
  tms_pkg::op_t                op;
  logic [tms_pkg::STATE_W-1:0] entry_state;
  logic [tms_pkg::SYM_W-1:0]   entry_symbol;
  logic [tms_pkg::SYM_W-1:0]   entry_write;
  logic                        entry_right;
  logic [tms_pkg::STATE_W-1:0] entry_next;
  logic                        entry_halts;
  logic [tms_pkg::HEAD_W-1:0]  cell_index;

  assign op           = tms_pkg::op_t'(s_axis_tuser);
  assign entry_state  = s_axis_tdata[2:0];
  assign entry_symbol = s_axis_tdata[4:3];
  assign entry_write  = s_axis_tdata[6:5];
  assign entry_right  = s_axis_tdata[7];
  assign entry_next   = s_axis_tdata[10:8];
  assign entry_halts  = s_axis_tdata[11];
  assign cell_index   = s_axis_tdata[20:12];

  // ---------------------------------------------------------------------------
  // Pipeline handshake: three stages, each loads when empty or draining.
  // Stage 3 is the output register; while a result waits, stages 1 and 2 still fill.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;
  logic accept;

  assign rdy3          = !v3 || m_axis_tready;
  assign rdy2          = !v2 || rdy3;
  assign rdy1          = !v1 || rdy2;
  assign s_axis_tready = rdy1;
  assign accept        = s_axis_tvalid && rdy1;

  // ---------------------------------------------------------------------------
  // Machine state
  // ---------------------------------------------------------------------------
  logic [tms_pkg::STATE_W-1:0] machine_state, machine_state_next;
  logic [tms_pkg::HEAD_W-1:0]  head, head_next;
  logic                        halted, halted_next;
  logic                        off_tape, off_tape_next;

  tms_pkg::tape_ctl_t          tape_ctl;
  logic [tms_pkg::SYM_W-1:0]   head_sym;
  logic [tms_pkg::SYM_W-1:0]   tree_sym;

  tms_pkg::rule_t              rule;
  tms_pkg::rule_t              load_rule;
  logic                        tbl_we;

  logic [tms_pkg::SCNT_W-1:0]  ns;
  logic [tms_pkg::YCNT_W-1:0]  ny;
  logic                        load_bad;
  logic                        blocked;
  tms_pkg::res_t               res;

  tms_rule_table u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr ({entry_state, entry_symbol}),
    .wdata (load_rule),
    .raddr ({machine_state, head_sym}),
    .rdata (rule)
  );

  // head cell is always ring position 0, so a tape address maps to
  // ring position (address - head) modulo the tape length
  tms_tape u_tape (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tape_ctl),
    .head_sym (head_sym),
    .rd_ld    (accept && op == tms_pkg::OP_READ),
    .rd_addr  (cell_index - head),
    .rd_adv   (rdy2 && v1),
    .cell_sym (tree_sym)
  );

  always_comb begin
    // counts above the table size act as the table size
    ns = (state_count > tms_pkg::SCNT_MAX) ? tms_pkg::SCNT_MAX : state_count;
    ny = (symbol_count > tms_pkg::YCNT_MAX) ? tms_pkg::YCNT_MAX : symbol_count;
    load_bad = ({1'b0, entry_state} >= ns) ||
               ({1'b0, entry_symbol} >= ny) ||
               ({1'b0, entry_write} >= ny) ||
               (!entry_halts && ({1'b0, entry_next} >= ns));

    load_rule.write_sym = entry_write;
    load_rule.right     = entry_right;
    load_rule.next      = entry_halts ? '0 : entry_next;
    load_rule.halts     = entry_halts;

    blocked = rule.right ? (head == tms_pkg::HEAD_LAST) : (head == '0);

    machine_state_next = machine_state;
    head_next          = head;
    halted_next        = halted;
    off_tape_next      = off_tape;
    tbl_we             = 1'b0;
    tape_ctl           = '0;
    res                = '0;

    if (accept) begin
      case (op)
        tms_pkg::OP_LOAD: begin
          tbl_we         = !load_bad;
          res.load_error = load_bad;
        end
        tms_pkg::OP_STEP: begin
          // a halted or stranded machine ignores steps
          if (!halted && !off_tape) begin
            tape_ctl.we     = 1'b1;
            tape_ctl.wd     = rule.write_sym;
            res.sym_written = rule.write_sym;
            if (rule.halts) begin
              halted_next = 1'b1;
            end
            if (blocked) begin
              // refused move: symbol written, head and state kept
              off_tape_next = 1'b1;
            end else begin
              tape_ctl.shift  = 1'b1;
              tape_ctl.right  = rule.right;
              head_next       = rule.right ? head + 1'b1 : head - 1'b1;
              res.moved_right = rule.right;
              if (!rule.halts) begin
                machine_state_next = rule.next;
              end
            end
          end
        end
        tms_pkg::OP_RESTART: begin
          tape_ctl.clr       = 1'b1;
          head_next          = tms_pkg::HEAD_RESET;
          machine_state_next = '0;
          halted_next        = 1'b0;
          off_tape_next      = 1'b0;
        end
        tms_pkg::OP_READ: begin
          res.rd = 1'b1;
        end
        default: ;
      endcase
    end

    res.state    = machine_state_next;
    res.head     = head_next;
    res.halted   = halted_next;
    res.off_tape = off_tape_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      machine_state <= '0;
      head          <= tms_pkg::HEAD_RESET;
      halted        <= 1'b0;
      off_tape      <= 1'b0;
    end else begin
      machine_state <= machine_state_next;
      head          <= head_next;
      halted        <= halted_next;
      off_tape      <= off_tape_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result pipeline; the tape read tree runs alongside stages 1 and 2
  // ---------------------------------------------------------------------------
  tms_pkg::res_t             r1, r2, r3;
  logic [tms_pkg::SYM_W-1:0] cell3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= accept;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r1 <= res;
    end
    if (rdy2 && v1) begin
      r2 <= r1;
    end
    if (rdy3 && v2) begin
      r3    <= r2;
      cell3 <= r2.rd ? tree_sym : '0;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = {{(tms_pkg::M_DATA_W - tms_pkg::M_FIELD_W){1'b0}},
                          r3.load_error, cell3, r3.off_tape, r3.halted,
                          r3.moved_right, r3.sym_written, r3.head, r3.state};

endmodule

// ===== hw/rtl/tms_checker.sv =====
// tms_checker: port-level checks of turing_machine_stepper, bound to the top.
// Depends on tms_pkg and turing_machine_stepper.
module tms_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [tms_pkg::M_DATA_W-1:0]   m_axis_tdata
);

  logic out_moved, out_off, out_lerr;
  logic [tms_pkg::SYM_W-1:0] out_written, out_cell;

  assign out_written = m_axis_tdata[13:12];
  assign out_moved   = m_axis_tdata[14];
  assign out_off     = m_axis_tdata[16];
  assign out_cell    = m_axis_tdata[18:17];
  assign out_lerr    = m_axis_tdata[19];

  // nothing in flight straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a head that moved cannot leave the machine stranded
  a_move_on_tape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_moved |-> !out_off)
    else $error("moved and off tape in one result");

  // a rejected load touches neither tape nor head
  a_load_err_quiet: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_lerr |-> out_written == '0 && !out_moved && out_cell == '0)
    else $error("load error with step or read fields set");

endmodule

bind turing_machine_stepper tms_checker u_tms_checker (.*);
